[design/spq_pkg.sv]
package spq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned PRIO_WIDTH_DEF = 8;

  // capacity register
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CAP_RESET = 16;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'h0;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

[design/spq_cell.sv]
module spq_cell #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned PRIO_WIDTH = 8
) (
  input  logic                         clk_i,
  input  spq_pkg::cell_ctrl_t          ctrl_i,
  input  logic                         valid_i,
  input  logic        [DATA_WIDTH-1:0] new_data_i,
  input  logic signed [PRIO_WIDTH-1:0] new_prio_i,
  input  logic                         left_keep_i,
  input  logic        [DATA_WIDTH-1:0] left_data_i,
  input  logic signed [PRIO_WIDTH-1:0] left_prio_i,
  input  logic        [DATA_WIDTH-1:0] right_data_i,
  input  logic signed [PRIO_WIDTH-1:0] right_prio_i,
  output logic                         keep_o,
  output logic        [DATA_WIDTH-1:0] data_o,
  output logic signed [PRIO_WIDTH-1:0] prio_o
);
  import spq_pkg::*;

  logic        [DATA_WIDTH-1:0] data_q, data_d;
  logic signed [PRIO_WIDTH-1:0] prio_q, prio_d;

  // entry stays put when it sorts at or before the newcomer
  assign keep_o = valid_i && (prio_q <= new_prio_i);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.enq && !keep_o) begin
      if (left_keep_i) begin
        data_d = new_data_i;
        prio_d = new_prio_i;
      end else begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end
    end else if (ctrl_i.deq) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule

[design/sorted_array_priority_queue_unit.sv]
// One command per cycle: busy is never raised, so start may be high every cycle.
// The result strobe (done_o) is registered at the accepting edge and shows in the cycle after it.
// All cells update in that same edge: each compares against the broadcast priority.
// Reset clears the entry count, sets capacity to 16 and drops any pending strobe.
// Results are shown for one cycle only; the receiver cannot stall.
module sorted_array_priority_queue_unit #(
  parameter int unsigned DEPTH      = spq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command_i,
  input  logic        [DATA_WIDTH-1:0]         item_data_i,
  input  logic signed [PRIO_WIDTH-1:0]         item_priority_i,
  output logic                                 done_o,
  output logic        [1:0]                    status_o,
  output logic        [DATA_WIDTH-1:0]         head_data_o,
  output logic signed [PRIO_WIDTH-1:0]         head_priority_o,
  output logic        [CW-1:0]                 occupancy_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [spq_pkg::APB_AW-1:0]    paddr,
  input  logic        [spq_pkg::APB_DW-1:0]    pwdata,
  output logic        [spq_pkg::APB_DW-1:0]    prdata,
  output logic                                 pready
);
  import spq_pkg::*;

  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    count_q, count_d;

  logic                         done_q;
  status_e                      status_q, status_d;
  logic        [DATA_WIDTH-1:0] hdata_q, hdata_d;
  logic signed [PRIO_WIDTH-1:0] hprio_q, hprio_d;
  logic        [CW-1:0]         occ_q;

  logic       accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  logic        [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic signed [PRIO_WIDTH-1:0] cell_prio [DEPTH];
  logic        [DEPTH-1:0]      cell_keep;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? APB_DW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q >= CW'(DEPTH));
  assign empty  = (count_q == '0);

  always_comb begin
    ctrl.enq = accept && (command_i == CMD_ENQ) && !full;
    ctrl.deq = accept && (command_i == CMD_DEQ) && !empty;
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_EMPTY;
    hdata_d  = '0;
    hprio_d  = '0;
    if (command_i == CMD_ENQ) begin
      status_d = full ? ST_OVERFLOW : ST_ADDED;
      if (!full) count_d = count_q + 1'b1;
    end else if (!empty) begin
      status_d = ST_REMOVED;
      hdata_d  = cell_data[0];
      hprio_d  = cell_prio[0];
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      hdata_q  <= hdata_d;
      hprio_q  <= hprio_d;
      occ_q    <= count_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign head_data_o     = hdata_q;
  assign head_priority_o = hprio_q;
  assign occupancy_o     = occ_q;

  // the chain: cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned L = (i == 0) ? 0 : i - 1;
    localparam int unsigned R = (i == DEPTH - 1) ? i : i + 1;

    spq_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .PRIO_WIDTH(PRIO_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (count_q > CW'(i)),
      .new_data_i  (item_data_i),
      .new_prio_i  (item_priority_i),
      .left_keep_i ((i == 0) ? 1'b1 : cell_keep[L]),
      .left_data_i (cell_data[L]),
      .left_prio_i (cell_prio[L]),
      .right_data_i(cell_data[R]),
      .right_prio_i(cell_prio[R]),
      .keep_o      (cell_keep[i]),
      .data_o      (cell_data[i]),
      .prio_o      (cell_prio[i])
    );
  end

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("missing result strobe");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o) else $error("result strobe without command");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("entry count beyond depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.enq |=> count_q == $past(count_q) + 1'b1) else $error("enqueue lost");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_REMOVED |-> head_data_o == '0 && head_priority_o == '0)
    else $error("head fields not cleared");

endmodule
